// ----- rtl/bol_pkg.sv -----
// ----------------------------------------------------------------------------
// bol_pkg
// Shared constants, operation codes and cell control types for the bounded
// ordered list.
// ----------------------------------------------------------------------------
package bol_pkg;

  localparam int DEF_CAPACITY = 16;
  localparam int DATA_W       = 32;
  localparam int OP_W         = 3;
  localparam int INDEX_W      = 4;
  localparam int STATUS_W     = 2;
  localparam int COUNT_W      = 5;

  // request operation codes
  localparam logic [OP_W-1:0] OP_PUSH_FRONT  = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK   = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT   = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK    = 3'd3;
  localparam logic [OP_W-1:0] OP_REMOVE_AT   = 3'd4;
  localparam logic [OP_W-1:0] OP_REMOVE_VAL  = 3'd5;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_PUSH_FRONT,
    CMD_PUSH_BACK,
    CMD_REMOVE_AT,
    CMD_REMOVE_MATCH
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t         cmd;
    logic [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage

// ----- rtl/bol_cell.sv -----
// ----------------------------------------------------------------------------
// bol_cell
// One list position: holds a value, shifts it towards either neighbour and
// takes part in the first-match chain for removals.
// ----------------------------------------------------------------------------
module bol_cell #(
  parameter int POS   = 0,
  parameter int CNT_W = 5
) (
  input  logic                       clk,
  input  bol_pkg::cell_ctrl_t        ctrl,
  input  logic [CNT_W-1:0]           pos,
  input  logic [CNT_W-1:0]           fill,
  input  logic [bol_pkg::DATA_W-1:0] left_data,
  input  logic [bol_pkg::DATA_W-1:0] right_data,
  input  logic                       found_in,
  output logic                       found_out,
  output logic [bol_pkg::DATA_W-1:0] data_out,
  output logic [bol_pkg::DATA_W-1:0] take_out
);

  logic [bol_pkg::DATA_W-1:0] data;
  logic [bol_pkg::DATA_W-1:0] data_next;
  logic                       in_use;
  logic                       at_pos;
  logic                       at_fill;
  logic                       hit;
  logic                       sel;

  assign in_use  = CNT_W'(POS) < fill;
  assign at_pos  = CNT_W'(POS) == pos;
  assign at_fill = CNT_W'(POS) == fill;

  assign hit = ((ctrl.cmd == bol_pkg::CMD_REMOVE_AT) && at_pos) ||
               ((ctrl.cmd == bol_pkg::CMD_REMOVE_MATCH) && in_use &&
                (data == ctrl.value));

  // first hit along the chain wins
  assign sel       = hit && !found_in;
  assign found_out = found_in || sel;
  assign take_out  = sel ? data : '0;
  assign data_out  = data;

  always_comb begin
    unique case (ctrl.cmd)
      bol_pkg::CMD_PUSH_FRONT:   data_next = left_data;
      bol_pkg::CMD_PUSH_BACK:    data_next = at_fill ? ctrl.value : data;
      bol_pkg::CMD_REMOVE_AT,
      bol_pkg::CMD_REMOVE_MATCH: data_next = found_out ? right_data : data;
      default:                   data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

// ----- rtl/bounded_ordered_list_core.sv -----
// ----------------------------------------------------------------------------
// bounded_ordered_list_core
// Ordered list of up to CAPACITY signed values with push, pop and remove.
// ----------------------------------------------------------------------------
// One request is taken per clock while the output register is not stalled,
// and its result appears in the output register on the next cycle, so the
// sustained rate is one request per cycle; a new request is taken whenever
// the output register is empty or being read in the same cycle. Every
// position is a cell of its own, all cells shift in the same cycle, and a
// remove-by-value search runs as a first-match chain through the row of
// cells, which sets the longest path. Entries are not cleared at reset;
// positions at or beyond the count are never reported.
module bounded_ordered_list_core #(
  parameter int CAPACITY = bol_pkg::DEF_CAPACITY
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [bol_pkg::OP_W-1:0]            op,
  input  logic signed [bol_pkg::DATA_W-1:0]   value,
  input  logic [bol_pkg::INDEX_W-1:0]         index,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [bol_pkg::STATUS_W-1:0]        status,
  output logic signed [bol_pkg::DATA_W-1:0]   removed_value,
  output logic [bol_pkg::COUNT_W-1:0]         count
);

  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int IDX_CMP_W = (CNT_W > bol_pkg::INDEX_W) ? CNT_W : bol_pkg::INDEX_W;

  logic                          in_accept;
  logic [CNT_W-1:0]              entry_count;
  logic [CNT_W-1:0]              entry_count_next;
  logic [bol_pkg::STATUS_W-1:0]  status_next;
  logic                          list_full;
  logic                          list_empty;
  logic                          index_ok;
  bol_pkg::cell_cmd_t            cmd;
  bol_pkg::cell_ctrl_t           ctrl;
  logic [CNT_W-1:0]              pos;
  logic [bol_pkg::DATA_W-1:0]    cell_data [CAPACITY];
  logic [bol_pkg::DATA_W-1:0]    cell_take [CAPACITY];
  logic [CAPACITY:0]             found;
  logic [bol_pkg::DATA_W-1:0]    removed_or;

  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  assign list_full  = entry_count == CNT_W'(CAPACITY);
  assign list_empty = entry_count == '0;
  assign index_ok   = IDX_CMP_W'(index) < IDX_CMP_W'(entry_count);

  // command to the cells
  always_comb begin
    cmd = bol_pkg::CMD_HOLD;
    pos = '0;
    unique case (op)
      bol_pkg::OP_PUSH_FRONT: begin
        if (!list_full) cmd = bol_pkg::CMD_PUSH_FRONT;
      end
      bol_pkg::OP_PUSH_BACK: begin
        if (!list_full) cmd = bol_pkg::CMD_PUSH_BACK;
      end
      bol_pkg::OP_POP_FRONT: begin
        if (!list_empty) cmd = bol_pkg::CMD_REMOVE_AT;
      end
      bol_pkg::OP_POP_BACK: begin
        if (!list_empty) begin
          cmd = bol_pkg::CMD_REMOVE_AT;
          pos = entry_count - 1'b1;
        end
      end
      bol_pkg::OP_REMOVE_AT: begin
        if (!list_empty && index_ok) begin
          cmd = bol_pkg::CMD_REMOVE_AT;
          pos = CNT_W'(index);
        end
      end
      bol_pkg::OP_REMOVE_VAL: begin
        if (!list_empty) cmd = bol_pkg::CMD_REMOVE_MATCH;
      end
      default: cmd = bol_pkg::CMD_HOLD;
    endcase
  end

  assign ctrl.cmd   = in_accept ? cmd : bol_pkg::CMD_HOLD;
  assign ctrl.value = value;
  assign found[0]   = 1'b0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [bol_pkg::DATA_W-1:0] left_data;
    logic [bol_pkg::DATA_W-1:0] right_data;

    if (g == 0) begin : g_head
      assign left_data = value;
    end else begin : g_body
      assign left_data = cell_data[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign right_data = cell_data[g];
    end else begin : g_inner
      assign right_data = cell_data[g+1];
    end

    bol_cell #(
      .POS   (g),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .pos        (pos),
      .fill       (entry_count),
      .left_data  (left_data),
      .right_data (right_data),
      .found_in   (found[g]),
      .found_out  (found[g+1]),
      .data_out   (cell_data[g]),
      .take_out   (cell_take[g])
    );
  end

  always_comb begin
    removed_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      removed_or = removed_or | cell_take[i];
    end
  end

  // status and new count
  always_comb begin
    status_next      = bol_pkg::ST_OK;
    entry_count_next = entry_count;
    unique case (op)
      bol_pkg::OP_PUSH_FRONT,
      bol_pkg::OP_PUSH_BACK: begin
        if (list_full) status_next = bol_pkg::ST_FULL;
        else entry_count_next = entry_count + 1'b1;
      end
      bol_pkg::OP_POP_FRONT,
      bol_pkg::OP_POP_BACK: begin
        if (list_empty) status_next = bol_pkg::ST_EMPTY;
        else entry_count_next = entry_count - 1'b1;
      end
      bol_pkg::OP_REMOVE_AT: begin
        if (list_empty) status_next = bol_pkg::ST_EMPTY;
        else if (!index_ok) status_next = bol_pkg::ST_NOT_FOUND;
        else entry_count_next = entry_count - 1'b1;
      end
      bol_pkg::OP_REMOVE_VAL: begin
        if (list_empty) status_next = bol_pkg::ST_EMPTY;
        else if (!found[CAPACITY]) status_next = bol_pkg::ST_NOT_FOUND;
        else entry_count_next = entry_count - 1'b1;
      end
      default: status_next = bol_pkg::ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (in_accept) begin
        entry_count <= entry_count_next;
        out_valid   <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      status        <= status_next;
      removed_value <= $signed(removed_or);
      count         <= bol_pkg::COUNT_W'(entry_count_next);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_result_count: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (out_valid && (count == bol_pkg::COUNT_W'(entry_count))))
    else $error("reported count differs from held count");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (in_accept && !list_full &&
     ((op == bol_pkg::OP_PUSH_FRONT) || (op == bol_pkg::OP_PUSH_BACK)))
    |=> ((status == bol_pkg::ST_OK) && (entry_count == $past(entry_count) + 1'b1)))
    else $error("push on a list with room did not grow it");

  a_remove_value: assert property (@(posedge clk) disable iff (rst)
    (in_accept && (op == bol_pkg::OP_REMOVE_VAL) && !list_empty && !found[CAPACITY])
    |=> ((status == bol_pkg::ST_NOT_FOUND) && (removed_value == '0)))
    else $error("missing value produced a removal");

endmodule

// ----- test/bounded_ordered_list_core_tb.sv -----
// ----------------------------------------------------------------------------
// bounded_ordered_list_core_tb
// Self-checking bench for the bounded ordered list. Requests are driven on the
// falling edge with random idle gaps on both sides. A shadow list predicts
// status, removed value and count for every accepted request, and each result
// is checked in order. Directed runs cover the empty list, the spare op codes,
// the extreme values, a full list and removal of the only entry. Random runs
// move the fill level up and down. One stretch holds the result side off so
// that the block backs up and stalls its input.
// ----------------------------------------------------------------------------
module bounded_ordered_list_core_tb;

  localparam int CAPACITY      = bol_pkg::DEF_CAPACITY;
  localparam int WATCHDOG_MAX  = 2000;
  localparam int HOLD_OFF_LEN  = 80;
  localparam logic [bol_pkg::OP_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [bol_pkg::OP_W-1:0] OP_SPARE_B = 3'd7;
  localparam logic signed [bol_pkg::DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [bol_pkg::DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct {
    logic [bol_pkg::STATUS_W-1:0]        status;
    logic signed [bol_pkg::DATA_W-1:0]   removed;
    logic [bol_pkg::COUNT_W-1:0]         count;
  } list_result_t;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  logic [bol_pkg::OP_W-1:0]            op = '0;
  logic signed [bol_pkg::DATA_W-1:0]   value = '0;
  logic [bol_pkg::INDEX_W-1:0]         index = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic [bol_pkg::STATUS_W-1:0]        status;
  logic signed [bol_pkg::DATA_W-1:0]   removed_value;
  logic [bol_pkg::COUNT_W-1:0]         count;

  logic signed [bol_pkg::DATA_W-1:0]   list_model[$];
  list_result_t                        pending_results[$];
  int                                  error_count = 0;
  int                                  quiet_cycles = 0;
  int                                  hold_cycles = 0;
  bit                                  idle_on = 1'b1;

  bounded_ordered_list_core #(.CAPACITY(CAPACITY)) DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .value        (value),
    .index        (index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .removed_value(removed_value),
    .count        (count)
  );

  always #4 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // shadow list update for one accepted request
  task automatic apply_list_op(input logic [bol_pkg::OP_W-1:0] opc,
                               input logic signed [bol_pkg::DATA_W-1:0] val,
                               input logic [bol_pkg::INDEX_W-1:0] idx,
                               output list_result_t res);
    int pos;
    res.status  = bol_pkg::ST_OK;
    res.removed = '0;
    pos = -1;
    case (opc)
      bol_pkg::OP_PUSH_FRONT, bol_pkg::OP_PUSH_BACK: begin
        if (list_model.size() >= CAPACITY) res.status = bol_pkg::ST_FULL;
        else if (opc == bol_pkg::OP_PUSH_FRONT) list_model.push_front(val);
        else list_model.push_back(val);
      end
      bol_pkg::OP_POP_FRONT, bol_pkg::OP_POP_BACK,
      bol_pkg::OP_REMOVE_AT, bol_pkg::OP_REMOVE_VAL: begin
        if (list_model.size() == 0) begin
          res.status = bol_pkg::ST_EMPTY;
        end else begin
          if (opc == bol_pkg::OP_POP_FRONT) pos = 0;
          else if (opc == bol_pkg::OP_POP_BACK) pos = list_model.size() - 1;
          else if (opc == bol_pkg::OP_REMOVE_AT) begin
            if (int'(idx) < list_model.size()) pos = int'(idx);
          end else begin
            for (int i = 0; i < list_model.size(); i++) begin
              if (list_model[i] == val) begin
                pos = i;
                break;
              end
            end
          end
          if (pos < 0) begin
            res.status = bol_pkg::ST_NOT_FOUND;
          end else begin
            res.removed = list_model[pos];
            list_model.delete(pos);
          end
        end
      end
      default: ;
    endcase
    res.count = bol_pkg::COUNT_W'(list_model.size());
  endtask

  task automatic issue_request(input logic [bol_pkg::OP_W-1:0] opc,
                               input logic signed [bol_pkg::DATA_W-1:0] val,
                               input logic [bol_pkg::INDEX_W-1:0] idx);
    list_result_t res;
    @(negedge clk);
    while (idle_on && $urandom_range(99) < 9) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    op       = opc;
    value    = val;
    index    = idx;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    apply_list_op(opc, val, idx, res);
    pending_results.push_back(res);
  endtask

  function automatic logic signed [bol_pkg::DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 5) return VAL_MIN;
    if (r < 10) return VAL_MAX;
    if (r < 15) return '0;
    if (r < 20) return -1;
    if (r < 55) return $signed($urandom_range(16)) - 8;
    return $urandom;
  endfunction

  function automatic logic [bol_pkg::INDEX_W-1:0] pick_index(input int top);
    return bol_pkg::INDEX_W'($urandom_range(top));
  endfunction

  // random request; push_weight sets how often the list grows
  task automatic issue_random_request(input int push_weight);
    int r;
    int pick;
    r = $urandom_range(99);
    if (r < 2) begin
      issue_request(($urandom_range(1) != 0) ? OP_SPARE_B : OP_SPARE_A, $urandom,
                    pick_index(15));
    end else if (r < 2 + push_weight) begin
      issue_request(($urandom_range(1) != 0) ? bol_pkg::OP_PUSH_BACK :
                    bol_pkg::OP_PUSH_FRONT, pick_value(), pick_index(15));
    end else begin
      pick = $urandom_range(3);
      if (pick == 0) begin
        issue_request(bol_pkg::OP_POP_FRONT, $urandom, pick_index(15));
      end else if (pick == 1) begin
        issue_request(bol_pkg::OP_POP_BACK, $urandom, pick_index(15));
      end else if (pick == 2) begin
        if (list_model.size() > 0 && $urandom_range(9) < 7)
          issue_request(bol_pkg::OP_REMOVE_AT, $urandom,
                        pick_index(list_model.size() - 1));
        else
          issue_request(bol_pkg::OP_REMOVE_AT, $urandom, pick_index(15));
      end else begin
        if (list_model.size() > 0 && $urandom_range(9) < 7)
          issue_request(bol_pkg::OP_REMOVE_VAL,
                        list_model[$urandom_range(list_model.size() - 1)],
                        pick_index(15));
        else
          issue_request(bol_pkg::OP_REMOVE_VAL, pick_value(), pick_index(15));
      end
    end
  endtask

  task automatic test_empty_and_spare();
    issue_request(bol_pkg::OP_POP_FRONT, '0, '0);
    issue_request(bol_pkg::OP_POP_BACK, '0, '0);
    issue_request(bol_pkg::OP_REMOVE_AT, '0, '0);
    issue_request(bol_pkg::OP_REMOVE_VAL, '0, 4'd15);
    issue_request(OP_SPARE_A, VAL_MAX, 4'd15);
    issue_request(OP_SPARE_B, VAL_MIN, '0);
  endtask

  task automatic test_push_and_remove();
    issue_request(bol_pkg::OP_PUSH_FRONT, VAL_MIN, '0);
    issue_request(bol_pkg::OP_PUSH_BACK, VAL_MAX, 4'd15);
    issue_request(bol_pkg::OP_PUSH_FRONT, '0, '0);
    issue_request(bol_pkg::OP_PUSH_BACK, -1, '0);
    issue_request(bol_pkg::OP_PUSH_FRONT, 32'sh5555_5555, '0);
    issue_request(bol_pkg::OP_REMOVE_VAL, 32'sh5555_5555, '0);
    issue_request(bol_pkg::OP_REMOVE_VAL, VAL_MAX, '0);
    issue_request(bol_pkg::OP_REMOVE_VAL, 32'sh1234_5678, '0);
    issue_request(bol_pkg::OP_REMOVE_AT, '0, 4'd15);
    issue_request(bol_pkg::OP_REMOVE_AT, '0, 4'd3);
    issue_request(bol_pkg::OP_REMOVE_AT, '0, 4'd2);
    issue_request(bol_pkg::OP_REMOVE_AT, '0, 4'd0);
    issue_request(bol_pkg::OP_POP_BACK, '0, '0);
    issue_request(bol_pkg::OP_POP_FRONT, '0, '0);
    // only entry removed by index, from the back and by value
    issue_request(bol_pkg::OP_PUSH_BACK, 32'sh2aaa_aaaa, '0);
    issue_request(bol_pkg::OP_REMOVE_AT, '0, 4'd0);
    issue_request(bol_pkg::OP_PUSH_FRONT, VAL_MIN, '0);
    issue_request(bol_pkg::OP_POP_BACK, '0, '0);
    issue_request(bol_pkg::OP_PUSH_BACK, VAL_MAX, '0);
    issue_request(bol_pkg::OP_REMOVE_VAL, VAL_MAX, '0);
  endtask

  task automatic test_fill_and_drain();
    for (int i = 0; i < CAPACITY / 2; i++)
      issue_request(bol_pkg::OP_PUSH_BACK, i + 100, '0);
    for (int i = 0; i < CAPACITY / 2; i++)
      issue_request(bol_pkg::OP_PUSH_FRONT, -i - 100, '0);
    issue_request(bol_pkg::OP_PUSH_FRONT, VAL_MAX, '0);
    issue_request(bol_pkg::OP_PUSH_BACK, VAL_MIN, '0);
    issue_request(bol_pkg::OP_REMOVE_AT, '0, 4'd15);
    issue_request(bol_pkg::OP_PUSH_BACK, VAL_MIN, '0);
    issue_request(bol_pkg::OP_REMOVE_VAL, VAL_MIN, '0);
    issue_request(bol_pkg::OP_REMOVE_VAL, 102, '0);
    while (list_model.size() > 0) issue_request(bol_pkg::OP_POP_FRONT, '0, '0);
    issue_request(bol_pkg::OP_POP_FRONT, '0, '0);
  endtask

  task automatic test_random_ops();
    int weights[4] = '{75, 45, 25, 60};
    for (int n = 0; n < 360; n++) issue_random_request(weights[(n / 45) % 4]);
  endtask

  task automatic test_stall_pressure();
    hold_cycles = HOLD_OFF_LEN;
    for (int n = 0; n < 30; n++) issue_random_request(50);
  endtask

  task automatic test_no_idle_stretch();
    idle_on = 1'b0;
    for (int n = 0; n < 120; n++) issue_random_request((n < 60) ? 70 : 30);
    idle_on = 1'b1;
  endtask

  // result side
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall = 1'b1;
      hold_cycles--;
    end else begin
      out_stall = idle_on && ($urandom_range(99) < 9);
    end
  end

  always @(posedge clk) begin
    list_result_t exp_res;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result status %0d removed %0d count %0d",
                                  status, removed_value, count));
      end else begin
        exp_res = pending_results.pop_front();
        if (status !== exp_res.status)
          report_mismatch($sformatf("status got %0d exp %0d", status, exp_res.status));
        if (removed_value !== exp_res.removed)
          report_mismatch($sformatf("removed_value got %0d exp %0d",
                                    removed_value, exp_res.removed));
        if (count !== exp_res.count)
          report_mismatch($sformatf("count got %0d exp %0d", count, exp_res.count));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("bounded_ordered_list_core_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_empty_and_spare();
    test_push_and_remove();
    test_fill_and_drain();
    test_random_ops();
    test_stall_pressure();
    test_no_idle_stretch();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (error_count == 0) $display("bounded_ordered_list_core_tb OK");
    else $display("bounded_ordered_list_core_tb NOT OK");
    $finish;
  end

endmodule
